@@ rtl/sas_pkg.sv @@
// Shared types and constants for the shell argument splitter.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package sas_pkg;

   // Result kinds carried on the response channel.
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_ARGEND = 2'd1;
   localparam logic [1:0] KIND_OK     = 2'd2;
   localparam logic [1:0] KIND_ERR    = 2'd3;

   // Request commands.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_EOL  = 1'b1;

   // Bytes with a special meaning to the splitter.
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;

   // One response as it sits in the result queue.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } res_type;

endpackage

@@ rtl/shell_argument_splitter_top.sv @@
// Shell-style argument splitter: request register, parse state machine and result queue.
// Depends on sas_pkg for result kinds, special bytes and the result entry type.
`timescale 1ns / 1ps

// The splitter takes one request per cycle: a command-line byte or an
// end-of-line mark. It returns argument bytes, argument-end marks and a final
// line-ok or line-error verdict, in the same order a shell would split the
// line. An accepted request lands in a one-entry request register. From there
// a six-state parser produces zero, one or two responses at once and
// writes them into a four-entry result queue. The first response of a request
// is presented on the rsp_ ports once the request has passed through the
// request register and been written into the queue. Requests are taken at one
// per cycle as long as the queue has room for two responses. The response
// port drains one entry per cycle while rsp_stall is low, so a stream of
// requests that each make two responses (an end of line that closes an
// argument, or a backslash kept inside double quotes) fills the queue and
// stalls the request port. The last response of every request carries
// rsp_last. A line that ends inside quotes or after a dangling backslash gives
// a single error response and drops the partial argument. Reset returns the
// parser to the whitespace state and empties the queue.
module shell_argument_splitter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_in_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   // Parser state codes.
   localparam logic [2:0] ST_SPACES  = 3'd0;
   localparam logic [2:0] ST_ARG     = 3'd1;
   localparam logic [2:0] ST_SQ      = 3'd2;
   localparam logic [2:0] ST_DQ      = 3'd3;
   localparam logic [2:0] ST_ESC_OUT = 3'd4;
   localparam logic [2:0] ST_ESC_DQ  = 3'd5;

   // The result queue must hold two responses per request.
   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   // Request register.
   logic       in_vld_ff, in_vld_in;
   logic       in_cmd_ff;
   logic [7:0] in_char_ff;

   // Parser state.
   logic [2:0] state_ff, state_in;

   // Result queue.
   sas_pkg::res_type   fifo_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Parser outputs for the request held in the request register.
   sas_pkg::res_type res0, res1;
   logic [1:0]       res_n;
   logic [1:0]       push_n;
   logic             is_space;

   logic req_accept;
   logic proc;
   logic pop;

   // The held request is parsed once the queue can take two responses.
   assign proc       = in_vld_ff && (count_ff <= CNT_W'(QDEPTH - 2));
   assign req_stall  = in_vld_ff && !proc;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && !rsp_stall;

   assign rsp_kind     = fifo_ff[rd_ptr_ff].kind;
   assign rsp_out_byte = fifo_ff[rd_ptr_ff].out_byte;
   assign rsp_last     = fifo_ff[rd_ptr_ff].last;

   assign is_space = (in_char_ff == sas_pkg::CHAR_SPACE) ||
                     (in_char_ff == sas_pkg::CHAR_NL) ||
                     (in_char_ff == sas_pkg::CHAR_TAB);

   // Parser: next state and up to two responses for the held request.
   always_comb begin
      state_in = state_ff;
      res_n    = 2'd0;
      res0     = '0;
      res1     = '0;
      if (in_cmd_ff == sas_pkg::CMD_EOL) begin
         // End of line closes an open argument and gives the verdict.
         unique case (state_ff) inside
            ST_ARG: begin
               res_n      = 2'd2;
               res0.kind  = sas_pkg::KIND_ARGEND;
               res1.kind  = sas_pkg::KIND_OK;
            end
            ST_SQ, ST_DQ, ST_ESC_OUT, ST_ESC_DQ: begin
               res_n      = 2'd1;
               res0.kind  = sas_pkg::KIND_ERR;
            end
            default: begin
               res_n      = 2'd1;
               res0.kind  = sas_pkg::KIND_OK;
            end
         endcase
         state_in = ST_SPACES;
      end else begin
         unique case (state_ff) inside
            ST_SQ: begin
               if (in_char_ff == sas_pkg::CHAR_SQUOTE) begin
                  state_in = ST_ARG;
               end else begin
                  res_n         = 2'd1;
                  res0.kind     = sas_pkg::KIND_BYTE;
                  res0.out_byte = in_char_ff;
               end
            end
            ST_DQ: begin
               if (in_char_ff == sas_pkg::CHAR_DQUOTE) begin
                  state_in = ST_ARG;
               end else if (in_char_ff == sas_pkg::CHAR_BSLASH) begin
                  state_in = ST_ESC_DQ;
               end else begin
                  res_n         = 2'd1;
                  res0.kind     = sas_pkg::KIND_BYTE;
                  res0.out_byte = in_char_ff;
               end
            end
            ST_ESC_OUT: begin
               res_n         = 2'd1;
               res0.kind     = sas_pkg::KIND_BYTE;
               res0.out_byte = in_char_ff;
               state_in      = ST_ARG;
            end
            ST_ESC_DQ: begin
               // Inside double quotes the backslash survives unless it
               // escapes a quote or another backslash.
               if ((in_char_ff != sas_pkg::CHAR_DQUOTE) &&
                   (in_char_ff != sas_pkg::CHAR_BSLASH)) begin
                  res_n         = 2'd2;
                  res0.kind     = sas_pkg::KIND_BYTE;
                  res0.out_byte = sas_pkg::CHAR_BSLASH;
                  res1.kind     = sas_pkg::KIND_BYTE;
                  res1.out_byte = in_char_ff;
               end else begin
                  res_n         = 2'd1;
                  res0.kind     = sas_pkg::KIND_BYTE;
                  res0.out_byte = in_char_ff;
               end
               state_in = ST_DQ;
            end
            default: begin
               // Whitespace, bare argument, and the unused codes.
               if (in_char_ff == sas_pkg::CHAR_DQUOTE) begin
                  state_in = ST_DQ;
               end else if (in_char_ff == sas_pkg::CHAR_SQUOTE) begin
                  state_in = ST_SQ;
               end else if (in_char_ff == sas_pkg::CHAR_BSLASH) begin
                  state_in = ST_ESC_OUT;
               end else if (is_space) begin
                  if (state_ff == ST_ARG) begin
                     res_n     = 2'd1;
                     res0.kind = sas_pkg::KIND_ARGEND;
                  end
                  state_in = ST_SPACES;
               end else begin
                  res_n         = 2'd1;
                  res0.kind     = sas_pkg::KIND_BYTE;
                  res0.out_byte = in_char_ff;
                  state_in      = ST_ARG;
               end
            end
         endcase
      end
      // Flag the final response of this request.
      if (res_n == 2'd1) begin
         res0.last = 1'b1;
      end
      if (res_n == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   assign push_n    = proc ? res_n : 2'd0;
   assign in_vld_in = req_accept || (in_vld_ff && !proc);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= ST_SPACES;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (proc) begin
            state_ff <= state_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Request payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_cmd;
         in_char_ff <= req_in_char;
      end
   end

   // Result queue storage: the head entry is never overwritten while it
   // waits, since the queue accepts only when two free slots remain.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

endmodule

@@ rtl/sas_checker.sv @@
// Port-level checker for the shell argument splitter, bound to the top level.
// Depends on sas_pkg for the result kind codes.
`timescale 1ns / 1ps

module sas_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_cmd,
   input logic [7:0] req_in_char,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // Leaving reset, no response is pending and requests are taken.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("response pending or request stalled after reset");

   // A stalled request stays on the port unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_cmd) && $stable(req_in_char)))
      else $error("stalled request changed");

   // A line verdict always ends the responses of its request.
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_kind == sas_pkg::KIND_OK) ||
                     (rsp_kind == sas_pkg::KIND_ERR))) |-> rsp_last)
      else $error("line verdict without last flag");

   // Only argument bytes carry a byte value.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != sas_pkg::KIND_BYTE)) |-> (rsp_out_byte == 8'd0))
      else $error("nonzero byte on a non-byte response");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind shell_argument_splitter_top sas_checker u_sas_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for shell_argument_splitter_top: directed and random command lines.
// Depends on sas_pkg for result kinds, request commands, special bytes and res_type.
`timescale 1ns / 1ps

// Overview
// An initial block builds every request up front into line_q. It starts with a short
// directed part, then generates random command lines until about 1550 requests are
// queued. Most random lines are well formed: words built from bare bytes, single
// quoted runs, double quoted runs with escapes and backslash escapes outside quotes,
// with runs of whitespace between them. About one line in ten ends inside quotes or
// an escape, and about one in eight is noise made of arbitrary bytes.
//
// The driver works on the falling edge and the monitor on the rising edge, so no
// sample depends on the order of events within a time step. The monitor runs a
// private copy of the splitter on each accepted request. It queues the tokens that
// request should produce, and it compares each accepted response with the oldest
// queued token.
module tb;

   // Parser states of the bench's own splitter copy.
   localparam logic [2:0] SPLIT_BLANK  = 3'd0;
   localparam logic [2:0] SPLIT_WORD   = 3'd1;
   localparam logic [2:0] SPLIT_SQUOTE = 3'd2;
   localparam logic [2:0] SPLIT_DQUOTE = 3'd3;
   localparam logic [2:0] SPLIT_ESC    = 3'd4;
   localparam logic [2:0] SPLIT_DQ_ESC = 3'd5;

   // One pending request. When hold is set, the driver keeps this request back until
   // every token that is already owed has come out of the block.
   typedef struct {
      logic       cmd;
      logic [7:0] ch;
      bit         hold;
   } line_item_type;

   // No acceptance on either channel for this many cycles means the block is hung.
   // The longest quiet stretch in a correct run is the receiver holdoff. The random
   // gaps at 82 percent idling are much shorter.
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLDOFF_LEN = 160;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic       req_cmd     = sas_pkg::CMD_BYTE;
   logic [7:0] req_in_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   line_item_type    line_q[$];
   sas_pkg::res_type token_q[$];
   logic [2:0]       split_state = SPLIT_BLANK;

   bit req_fired    = 1'b0;
   int total_items  = 0;
   int acc_cnt      = 0;
   int rsp_cnt      = 0;
   int err_cnt      = 0;
   int lines_ok     = 0;
   int lines_bad    = 0;
   int quiet_cycles = 0;
   int next_hold_at = 300;
   int holdoff_left = 0;
   int next_holdoff = 150;

   shell_argument_splitter_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_in_char  (req_in_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic push_item(input logic cmd, input logic [7:0] ch);
      line_item_type it;
      it.cmd  = cmd;
      it.ch   = ch;
      it.hold = 1'b0;
      line_q.insert(line_q.size(), it);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(sas_pkg::CMD_BYTE, s[i]);
   endtask

   // Picks any byte. The special bytes are weighted heavily so that they show up often.
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 9))
         0: return sas_pkg::CHAR_DQUOTE;
         1: return sas_pkg::CHAR_SQUOTE;
         2: return sas_pkg::CHAR_BSLASH;
         3: return sas_pkg::CHAR_SPACE;
         4: return sas_pkg::CHAR_NL;
         5: return sas_pkg::CHAR_TAB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Picks a byte that the splitter treats as ordinary. None of the special bytes has
   // bit 7 set, so flipping bit 7 always turns a special byte into an ordinary one.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b inside {sas_pkg::CHAR_DQUOTE, sas_pkg::CHAR_SQUOTE, sas_pkg::CHAR_BSLASH,
                    sas_pkg::CHAR_SPACE, sas_pkg::CHAR_NL, sas_pkg::CHAR_TAB})
         b = b ^ 8'h80;
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 2))
         0: return sas_pkg::CHAR_SPACE;
         1: return sas_pkg::CHAR_TAB;
         default: return sas_pkg::CHAR_NL;
      endcase
   endfunction

   // Generates one random command line, ending with an end-of-line request.
   task automatic gen_line();
      int            start;
      logic [7:0]    b;
      line_item_type head;
      start = line_q.size();
      if ($urandom_range(0, 7) == 0) begin
         // Noise: arbitrary bytes, which can end in any state.
         repeat ($urandom_range(3, 10)) push_item(sas_pkg::CMD_BYTE, any_byte());
      end else begin
         repeat ($urandom_range(0, 2)) push_item(sas_pkg::CMD_BYTE, blank_byte());
         repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 3))
                  0: begin
                     repeat ($urandom_range(1, 4)) push_item(sas_pkg::CMD_BYTE, plain_byte());
                  end
                  1: begin
                     push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_SQUOTE);
                     repeat ($urandom_range(0, 4)) begin
                        b = any_byte();
                        if (b == sas_pkg::CHAR_SQUOTE) b = b ^ 8'h80;
                        push_item(sas_pkg::CMD_BYTE, b);
                     end
                     push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_SQUOTE);
                  end
                  2: begin
                     push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_DQUOTE);
                     repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 2) == 0) begin
                           push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_BSLASH);
                           push_item(sas_pkg::CMD_BYTE, any_byte());
                        end else begin
                           b = any_byte();
                           if (b == sas_pkg::CHAR_DQUOTE || b == sas_pkg::CHAR_BSLASH)
                              b = b ^ 8'h80;
                           push_item(sas_pkg::CMD_BYTE, b);
                        end
                     end
                     push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_DQUOTE);
                  end
                  default: begin
                     push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_BSLASH);
                     push_item(sas_pkg::CMD_BYTE, any_byte());
                  end
               endcase
            end
            repeat ($urandom_range(0, 2)) push_item(sas_pkg::CMD_BYTE, blank_byte());
         end
         // Now and then the line breaks off inside quotes or an escape.
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_SQUOTE);
                  repeat ($urandom_range(0, 2)) push_item(sas_pkg::CMD_BYTE, plain_byte());
               end
               1: begin
                  push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_DQUOTE);
                  repeat ($urandom_range(0, 2)) push_item(sas_pkg::CMD_BYTE, plain_byte());
               end
               2: push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_BSLASH);
               default: begin
                  push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_DQUOTE);
                  push_item(sas_pkg::CMD_BYTE, sas_pkg::CHAR_BSLASH);
               end
            endcase
         end
      end
      push_item(sas_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
      // Every few hundred requests, the sender waits for the block to drain.
      if (line_q.size() >= next_hold_at) begin
         head = line_q[start];
         head.hold = 1'b1;
         line_q[start] = head;
         next_hold_at += 400;
      end
   endtask

   // ---------------------------------------------------------------- splitter copy

   task automatic add_token(input logic [1:0] kind, input logic [7:0] b);
      sas_pkg::res_type t;
      t.kind     = kind;
      t.out_byte = b;
      t.last     = 1'b0;
      token_q.insert(token_q.size(), t);
   endtask

   // Runs one accepted request through the bench's splitter copy and queues the
   // tokens it should produce. The final token of the request gets the last flag.
   task automatic split_request(input logic cmd, input logic [7:0] ch);
      int               first;
      sas_pkg::res_type tail;
      first = token_q.size();
      if (cmd == sas_pkg::CMD_EOL) begin
         unique case (split_state) inside
            SPLIT_WORD: begin
               add_token(sas_pkg::KIND_ARGEND, 8'h00);
               add_token(sas_pkg::KIND_OK, 8'h00);
            end
            // A line that ends inside quotes or an escape drops its partial argument.
            SPLIT_SQUOTE, SPLIT_DQUOTE, SPLIT_ESC, SPLIT_DQ_ESC:
               add_token(sas_pkg::KIND_ERR, 8'h00);
            default: add_token(sas_pkg::KIND_OK, 8'h00);
         endcase
         split_state = SPLIT_BLANK;
      end else begin
         unique case (split_state) inside
            SPLIT_SQUOTE: begin
               if (ch == sas_pkg::CHAR_SQUOTE) split_state = SPLIT_WORD;
               else add_token(sas_pkg::KIND_BYTE, ch);
            end
            SPLIT_DQUOTE: begin
               if (ch == sas_pkg::CHAR_DQUOTE) split_state = SPLIT_WORD;
               else if (ch == sas_pkg::CHAR_BSLASH) split_state = SPLIT_DQ_ESC;
               else add_token(sas_pkg::KIND_BYTE, ch);
            end
            SPLIT_ESC: begin
               add_token(sas_pkg::KIND_BYTE, ch);
               split_state = SPLIT_WORD;
            end
            SPLIT_DQ_ESC: begin
               // Inside double quotes the backslash stays unless it escapes a quote or
               // another backslash.
               if (ch != sas_pkg::CHAR_DQUOTE && ch != sas_pkg::CHAR_BSLASH)
                  add_token(sas_pkg::KIND_BYTE, sas_pkg::CHAR_BSLASH);
               add_token(sas_pkg::KIND_BYTE, ch);
               split_state = SPLIT_DQUOTE;
            end
            default: begin
               if (ch == sas_pkg::CHAR_DQUOTE) begin
                  split_state = SPLIT_DQUOTE;
               end else if (ch == sas_pkg::CHAR_SQUOTE) begin
                  split_state = SPLIT_SQUOTE;
               end else if (ch == sas_pkg::CHAR_BSLASH) begin
                  split_state = SPLIT_ESC;
               end else if (ch == sas_pkg::CHAR_SPACE || ch == sas_pkg::CHAR_NL ||
                            ch == sas_pkg::CHAR_TAB) begin
                  if (split_state == SPLIT_WORD) add_token(sas_pkg::KIND_ARGEND, 8'h00);
                  split_state = SPLIT_BLANK;
               end else begin
                  add_token(sas_pkg::KIND_BYTE, ch);
                  split_state = SPLIT_WORD;
               end
            end
         endcase
      end
      if (token_q.size() > first) begin
         tail = token_q[token_q.size() - 1];
         tail.last = 1'b1;
         token_q[token_q.size() - 1] = tail;
      end
   endtask

   task automatic flag_error(input string msg);
      err_cnt++;
      if (err_cnt <= 10) $display("ERROR: %s", msg);
   endtask

   // ---------------------------------------------------------------- idling mix

   // The run has three parts of equal size. In the first, the sender idles rarely and
   // the receiver idles often. The second reverses the two. In the third, neither idles.
   function automatic int sender_idle_pct();
      if (acc_cnt < total_items / 3) return 6;
      else if (acc_cnt < (2 * total_items) / 3) return 82;
      else return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (acc_cnt < total_items / 3) return 82;
      else if (acc_cnt < (2 * total_items) / 3) return 6;
      else return 0;
   endfunction

   // ---------------------------------------------------------------- driver

   // The driver changes inputs on the falling edge. A stalled request is held as it is.
   // Once a request is accepted, or the channel is empty, the driver either offers the
   // next request or idles.
   always @(negedge clock) begin : drive_req
      line_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // Still stalled: keep the same request on the port.
      end else if (line_q.size() == 0 || $urandom_range(0, 99) < sender_idle_pct() ||
                   (line_q[0].hold && token_q.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         nxt = line_q.pop_front();
         req_valid   <= 1'b1;
         req_cmd     <= nxt.cmd;
         req_in_char <= nxt.ch;
      end
   end

   // The receiver stalls at random according to the current mix. Twice in the run it
   // holds off for a long stretch, once in the first part and once in the last part.
   // The sender keeps offering requests during each stretch, so the result queue
   // fills and the block has to stall its input.
   always @(negedge clock) begin
      if (holdoff_left != 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!reset && acc_cnt >= next_holdoff) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= HOLDOFF_LEN - 1;
         next_holdoff <= next_holdoff + 1000;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
      end
   end

   // ---------------------------------------------------------------- monitor

   // The monitor samples both channels on the rising edge. Each accepted request is
   // predicted before responses are checked. A response can only come out after its
   // request has been accepted, so this order is safe. The monitor also counts quiet
   // cycles and ends the run if the block stops moving.
   always @(posedge clock) begin : watch_ports
      sas_pkg::res_type want;
      bit               moved;
      moved = 1'b0;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         if (req_valid && req_stall === 1'b0) begin
            split_request(req_cmd, req_in_char);
            acc_cnt++;
            moved = 1'b1;
            req_fired <= 1'b1;
         end else begin
            req_fired <= 1'b0;
         end
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            rsp_cnt++;
            moved = 1'b1;
            if (rsp_kind === sas_pkg::KIND_OK) lines_ok++;
            if (rsp_kind === sas_pkg::KIND_ERR) lines_bad++;
            if (token_q.size() == 0) begin
               flag_error($sformatf("response %0d not expected: kind %0d byte %02h last %0b",
                                    rsp_cnt, rsp_kind, rsp_out_byte, rsp_last));
            end else begin
               want = token_q.pop_front();
               if (rsp_kind !== want.kind || rsp_out_byte !== want.out_byte ||
                   rsp_last !== want.last)
                  flag_error($sformatf(
                     {"response %0d: expected kind %0d byte %02h last %0b, ",
                      "got kind %0d byte %02h last %0b"},
                     rsp_cnt, want.kind, want.out_byte, want.last,
                     rsp_kind, rsp_out_byte, rsp_last));
            end
         end
         if (moved) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TIMEOUT: no request or response accepted for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // Directed part. An empty line reports ok only, and the end-of-line byte is ignored.
      push_item(sas_pkg::CMD_EOL, 8'hFF);
      // The extreme bytes form an argument, and a tab closes it. A single quoted
      // backslash is taken literally. In double quotes, an escaped quote and an escaped
      // backslash lose the backslash, but an escaped q keeps it. Outside quotes, an
      // escaped space is an argument byte. A newline closes the argument. An empty
      // quoted string still forms an argument, which the end of line closes.
      push_item(sas_pkg::CMD_BYTE, 8'h00);
      push_item(sas_pkg::CMD_BYTE, 8'hFF);
      push_text("\t'\\'\"\\\"\\\\\\q\"\\ \n''");
      push_item(sas_pkg::CMD_EOL, 8'h00);
      // The line ends inside single quotes, inside double quotes, after a bare
      // backslash and after a backslash inside double quotes.
      push_text("'");
      push_item(sas_pkg::CMD_EOL, 8'h00);
      push_text("\"");
      push_item(sas_pkg::CMD_EOL, 8'h00);
      push_text("\\");
      push_item(sas_pkg::CMD_EOL, 8'h00);
      push_text("\"\\");
      push_item(sas_pkg::CMD_EOL, 8'h00);

      // Random part.
      while (line_q.size() < 1550) gen_line();
      total_items = line_q.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every request has been taken and every owed token has come out.
      // Then wait a little longer, so that a stray extra response would still be seen.
      while (acc_cnt < total_items) @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Summary: %0d requests split into %0d responses; %0d lines ok, %0d lines bad.",
               acc_cnt, rsp_cnt, lines_ok, lines_bad);
      $display("Summary: three stall mixes, two receiver holdoffs, drain pauses; %0d mismatches.",
               err_cnt);
      if (err_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
